/* rtl/lec_pkg.sv */
// Shared types, constants and helpers for the local extrema counter.
package lec_pkg;

	localparam int DEF_MAX_ROWS     = 16;
	localparam int DEF_MAX_COLS     = 16;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam int SIZE_W  = 5;
	localparam int TALLY_W = 9;
	localparam int CNT_W   = 3;

	localparam int NBR_CNT = 8;
	localparam int ROW_STEP [NBR_CNT] = '{-1, -1, -1, 0, 1, 1, 1, 0};
	localparam int COL_STEP [NBR_CNT] = '{-1, 0, 1, 1, 1, 0, -1, -1};

	// result queue depth, also the number of frame ends allowed in flight
	localparam int QDEPTH   = 8;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int CREDIT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} lec_reg_t;

	// position flags of one sample, and which window centers it settles
	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic col_ge1;
		logic col_ge2;
		logic en_a;   // (i-1, j-1)
		logic en_b;   // (i-1, j) at row end
		logic en_c;   // (i, j-1) on last row
		logic en_d;   // (i, j) at last cell
	} lec_ctl_t;

	typedef struct packed {
		logic             last;
		logic [CNT_W-1:0] max_cnt;
		logic [CNT_W-1:0] min_cnt;
	} lec_cnt_t;

	typedef struct packed {
		logic [TALLY_W-1:0] maxima;
		logic [TALLY_W-1:0] minima;
		logic [TALLY_W-1:0] extrema;
	} lec_result_t;

	function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] a,
			input logic [TALLY_W-1:0] b);
		logic [TALLY_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TALLY_W] ? {TALLY_W{1'b1}} : s[TALLY_W-1:0];
	endfunction

endpackage

/* rtl/local_extrema_counter_top.sv */
// Local extrema counter: strict 3x3 maxima/minima tally over a raster-order matrix.
// Throughput: one sample per cycle while sample_stall is low; the line store is read and
// written back per accepted sample. Results pass window and count registers to a queue.
// Up to 8 frame results may be queued or in flight before sample_stall rises.
// Reset clears position, tallies, result queue; row/col counts reset to 1.
// Line store contents are undefined after reset and need no clearing pass.
module local_extrema_counter_top #(
	parameter int MAX_ROWS     = lec_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS     = lec_pkg::DEF_MAX_COLS,
	parameter int SAMPLE_WIDTH = lec_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  lec_pkg::lec_reg_t              cfg_index,
	input  logic [lec_pkg::SIZE_W-1:0]     cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [lec_pkg::TALLY_W-1:0]    maxima_count,
	output logic [lec_pkg::TALLY_W-1:0]    minima_count,
	output logic [lec_pkg::TALLY_W-1:0]    extrema_count
);
	import lec_pkg::*;

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [SIZE_W-1:0]   row_count_q, col_count_q;
	logic [ROW_W-1:0]    row_pos_q, rows_last;
	logic [COL_W-1:0]    col_pos_q, cols_last;
	logic [CREDIT_W-1:0] credit_q;
	logic                cfg_wr, accept, pop;
	logic                row_last, col_last, frame_end;
	lec_ctl_t            ctl;
	logic                col_valid;
	logic signed [SAMPLE_WIDTH-1:0] col_top, col_mid, col_bot;
	lec_ctl_t            col_ctl;
	logic                cnt_valid;
	lec_cnt_t            cnt;

	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign sample_stall = (credit_q == CREDIT_W'(QDEPTH));
	assign accept       = sample_valid && !sample_stall;
	assign pop          = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= SIZE_W'(1);
			col_count_q <= SIZE_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (row_count_q == '0) begin
			rows_last = '0;
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_last = ROW_W'(MAX_ROWS - 1);
		end else begin
			rows_last = ROW_W'(row_count_q - SIZE_W'(1));
		end
		if (col_count_q == '0) begin
			cols_last = '0;
		end else if (int'(col_count_q) > MAX_COLS) begin
			cols_last = COL_W'(MAX_COLS - 1);
		end else begin
			cols_last = COL_W'(col_count_q - SIZE_W'(1));
		end
	end

	assign row_last  = (row_pos_q == rows_last);
	assign col_last  = (col_pos_q == cols_last);
	assign frame_end = row_last && col_last;

	always_comb begin
		ctl.row_ge1 = (row_pos_q != '0);
		ctl.row_ge2 = (row_pos_q > ROW_W'(1));
		ctl.col_ge1 = (col_pos_q != '0);
		ctl.col_ge2 = (col_pos_q > COL_W'(1));
		ctl.en_a    = ctl.row_ge1 && ctl.col_ge1;
		ctl.en_b    = ctl.row_ge1 && col_last;
		ctl.en_c    = row_last && ctl.col_ge1;
		ctl.en_d    = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
		end else if (cfg_wr) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
		end else if (accept) begin
			priority if (frame_end) begin
				row_pos_q <= '0;
				col_pos_q <= '0;
			end else if (col_last) begin
				row_pos_q <= row_pos_q + 1'b1;
				col_pos_q <= '0;
			end else begin
				col_pos_q <= col_pos_q + 1'b1;
			end
		end
	end

	// frame ends in flight or queued; bounds the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CREDIT_W'(accept && frame_end) - CREDIT_W'(pop);
		end
	end

	lec_line_store #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_COLS     (MAX_COLS)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.col       (col_pos_q),
		.sample    (sample),
		.ctl       (ctl),
		.col_valid (col_valid),
		.top       (col_top),
		.mid       (col_mid),
		.bot       (col_bot),
		.col_ctl   (col_ctl)
	);

	lec_window_eval #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_window_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.top       (col_top),
		.mid       (col_mid),
		.bot       (col_bot),
		.col_ctl   (col_ctl),
		.cnt_valid (cnt_valid),
		.cnt       (cnt)
	);

	lec_tally u_tally (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (cfg_wr),
		.cnt_valid     (cnt_valid),
		.cnt           (cnt),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.maxima_count  (maxima_count),
		.minima_count  (minima_count),
		.extrema_count (extrema_count)
	);

endmodule

/* rtl/lec_line_store.sv */
// Two-row line store with read-modify-write per column and same-column forwarding.
module lec_line_store #(
	parameter int SAMPLE_WIDTH = lec_pkg::DEF_SAMPLE_WIDTH,
	parameter int MAX_COLS     = lec_pkg::DEF_MAX_COLS,
	localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [COL_W-1:0]               col,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  lec_pkg::lec_ctl_t              ctl,
	output logic                           col_valid,
	output logic signed [SAMPLE_WIDTH-1:0] top,
	output logic signed [SAMPLE_WIDTH-1:0] mid,
	output logic signed [SAMPLE_WIDTH-1:0] bot,
	output lec_pkg::lec_ctl_t              col_ctl
);
	import lec_pkg::*;

	localparam int WORD_W = 2 * SAMPLE_WIDTH;

	// word: upper half is row i-1, lower half row i-2
	logic [WORD_W-1:0]       mem [MAX_COLS];
	logic [WORD_W-1:0]       rd_q;
	logic [WORD_W-1:0]       fwd_word_q;
	logic [WORD_W-1:0]       word;
	logic [WORD_W-1:0]       wr_word;
	logic                    fwd_s1;
	logic                    valid_s1;
	logic [COL_W-1:0]        col_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	lec_ctl_t                ctl_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[col];
		end
		if (valid_s1) begin
			mem[col_s1] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			// write and read of the same column at one edge: read sees old word
			fwd_s1   <= accept && valid_s1 && (col == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		fwd_word_q <= wr_word;
		if (accept) begin
			col_s1    <= col;
			sample_s1 <= sample;
			ctl_s1    <= ctl;
		end
	end

	assign word    = fwd_s1 ? fwd_word_q : rd_q;
	assign wr_word = {sample_s1, word[WORD_W-1:SAMPLE_WIDTH]};

	assign col_valid = valid_s1;
	assign top       = word[SAMPLE_WIDTH-1:0];
	assign mid       = word[WORD_W-1:SAMPLE_WIDTH];
	assign bot       = sample_s1;
	assign col_ctl   = ctl_s1;

endmodule

/* rtl/lec_window_eval.sv */
// 3x3 window registers and strict extremum tests for up to four centers per sample.
module lec_window_eval #(
	parameter int SAMPLE_WIDTH = lec_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           col_valid,
	input  logic signed [SAMPLE_WIDTH-1:0] top,
	input  logic signed [SAMPLE_WIDTH-1:0] mid,
	input  logic signed [SAMPLE_WIDTH-1:0] bot,
	input  lec_pkg::lec_ctl_t              col_ctl,
	output logic                           cnt_valid,
	output lec_pkg::lec_cnt_t              cnt
);
	import lec_pkg::*;

	// rows: 0 = i-2, 1 = i-1, 2 = i; cols: 0 = j-2, 1 = j-1, 2 = j
	logic signed [SAMPLE_WIDTH-1:0] win_q [3][3];
	logic                           valid_s2;
	lec_ctl_t                       ctl_s2;
	logic [2:0]                     row_ok;
	logic [2:0]                     col_ok;
	logic [1:0]                     res_a, res_b, res_c, res_d;
	logic [CNT_W-1:0]               max_cnt, min_cnt;
	logic                           valid_s3;
	lec_cnt_t                       cnt_s3;

	// returns {is_max, is_min}; neighbors outside the window are out of bounds
	function automatic logic [1:0] test_center(
			input logic signed [SAMPLE_WIDTH-1:0] w [3][3],
			input logic [2:0] r_ok, input logic [2:0] c_ok,
			input int r, input int c);
		logic is_max;
		logic is_min;
		int   nr;
		int   nc;
		is_max = 1'b1;
		is_min = 1'b1;
		for (int d = 0; d < NBR_CNT; d++) begin
			nr = r + ROW_STEP[d];
			nc = c + COL_STEP[d];
			if (nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2) begin
				if (r_ok[nr[1:0]] && c_ok[nc[1:0]]) begin
					if (w[r[1:0]][c[1:0]] <= w[nr[1:0]][nc[1:0]]) is_max = 1'b0;
					if (w[r[1:0]][c[1:0]] >= w[nr[1:0]][nc[1:0]]) is_min = 1'b0;
				end
			end
		end
		return {is_max, is_min};
	endfunction

	always_ff @(posedge clk) begin
		if (col_valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top;
			win_q[1][2] <= mid;
			win_q[2][2] <= bot;
			ctl_s2      <= col_ctl;
		end
		if (valid_s2) begin
			cnt_s3.last    <= ctl_s2.en_d;
			cnt_s3.max_cnt <= max_cnt;
			cnt_s3.min_cnt <= min_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= col_valid;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		row_ok = {1'b1, ctl_s2.row_ge1, ctl_s2.row_ge2};
		col_ok = {1'b1, ctl_s2.col_ge1, ctl_s2.col_ge2};
		res_a  = test_center(win_q, row_ok, col_ok, 1, 1);
		res_b  = test_center(win_q, row_ok, col_ok, 1, 2);
		res_c  = test_center(win_q, row_ok, col_ok, 2, 1);
		res_d  = test_center(win_q, row_ok, col_ok, 2, 2);
		max_cnt = CNT_W'(res_a[1] & ctl_s2.en_a) + CNT_W'(res_b[1] & ctl_s2.en_b)
			+ CNT_W'(res_c[1] & ctl_s2.en_c) + CNT_W'(res_d[1] & ctl_s2.en_d);
		min_cnt = CNT_W'(res_a[0] & ctl_s2.en_a) + CNT_W'(res_b[0] & ctl_s2.en_b)
			+ CNT_W'(res_c[0] & ctl_s2.en_c) + CNT_W'(res_d[0] & ctl_s2.en_d);
	end

	assign cnt_valid = valid_s3;
	assign cnt       = cnt_s3;

endmodule

/* rtl/lec_tally.sv */
// Saturating frame tallies and the result queue.
module lec_tally (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            restart,
	input  logic                            cnt_valid,
	input  lec_pkg::lec_cnt_t               cnt,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [lec_pkg::TALLY_W-1:0]     maxima_count,
	output logic [lec_pkg::TALLY_W-1:0]     minima_count,
	output logic [lec_pkg::TALLY_W-1:0]     extrema_count
);
	import lec_pkg::*;

	logic [TALLY_W-1:0]  max_tally_q, min_tally_q;
	logic [TALLY_W-1:0]  max_next, min_next;
	lec_result_t         queue_q [QDEPTH];
	lec_result_t         head;
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     fill_q;
	logic                push, pop;

	assign max_next = sat_add(max_tally_q, TALLY_W'(cnt.max_cnt));
	assign min_next = sat_add(min_tally_q, TALLY_W'(cnt.min_cnt));
	assign push     = cnt_valid && cnt.last;
	assign pop      = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tally_q <= '0;
			min_tally_q <= '0;
		end else if (restart || push) begin
			max_tally_q <= '0;
			min_tally_q <= '0;
		end else if (cnt_valid) begin
			max_tally_q <= max_next;
			min_tally_q <= min_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q].maxima  <= max_next;
			queue_q[wr_ptr_q].minima  <= min_next;
			queue_q[wr_ptr_q].extrema <= sat_add(max_next, min_next);
		end
	end

	// depth is a power of two, so pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	assign head          = queue_q[rd_ptr_q];
	assign result_valid  = (fill_q != '0);
	assign maxima_count  = head.maxima;
	assign minima_count  = head.minima;
	assign extrema_count = head.extrema;

endmodule
